// ===== rtl/bhpq_pkg.sv =====
// bhpq_pkg: shared constants, codes and types of the binary heap priority queue
// no dependencies; imported by the channel interfaces and every rtl module
`default_nettype none

package bhpq_pkg;

    localparam int DEPTH     = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W     = ADDR_W + 2;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [CMD_W-1:0]     cmd_code_t;
    typedef logic [STATUS_W-1:0]  status_code_t;
    typedef logic [COUNT_W-1:0]   count_t;

    // datapath commands from the controller
    typedef struct packed {
        logic take_item;
        logic set_result;
        logic hole_tail;
        logic rd_root;
        logic rd_tail;
        logic rd_parent;
        logic rd_left;
        logic rd_right;
        logic put_key;
        logic up_step;
        logic take_top;
        logic shrink;
        logic take_tail;
        logic take_left;
        logic dn_step;
        logic emit;
    } bhpq_cmd_t;

    // datapath status to the controller
    typedef struct packed {
        cmd_code_t cmd;
        logic      empty;
        logic      full;
        logic      pos_zero;
        logic      up_win;
        logic      left_ok;
        logic      dn_move;
        logic      out_free;
    } bhpq_stat_t;

    // true when key a is served strictly before key b
    function automatic logic outranks(input key_t a, input key_t b, input logic smallest_first);
        logic res;
        if (smallest_first)
        begin
            res = (a < b);
        end
        else
        begin
            res = (a > b);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bhpq_if.sv =====
// bhpq channel interfaces: item input, result output and mode register write
// depends on bhpq_pkg for payload types
`default_nettype none

interface bhpq_item_if;
    import bhpq_pkg::*;
    logic      valid;
    logic      ready;
    cmd_code_t command;
    key_t      key;
    modport source (output valid, output command, output key, input ready);
    modport sink (input valid, input command, input key, output ready);
endinterface

interface bhpq_result_if;
    import bhpq_pkg::*;
    logic         valid;
    logic         ready;
    key_t         top_key;
    status_code_t status;
    count_t       entry_count;
    modport source (output valid, output top_key, output status, output entry_count,
                    input ready);
    modport sink (input valid, input top_key, input status, input entry_count,
                  output ready);
endinterface

interface bhpq_cfg_if;
    logic valid;
    logic ready;
    logic order_mode;
    modport source (output valid, output order_mode, input ready);
    modport sink (input valid, input order_mode, output ready);
endinterface

`default_nettype wire

// ===== rtl/bhpq_datapath.sv =====
// bhpq_datapath: heap memory, working registers, compares and the result register
// depends on bhpq_pkg; driven by bhpq_ctrl through bhpq_cmd_t
`default_nettype none

module bhpq_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire bhpq_pkg::cmd_code_t    item_command,
    input  wire bhpq_pkg::key_t         item_key,
    input  wire logic                   cfg_valid,
    input  wire logic                   cfg_order_mode,
    output logic                        cfg_ready,
    input  wire bhpq_pkg::bhpq_cmd_t    cmd,
    output bhpq_pkg::bhpq_stat_t        stat,
    output logic                        result_valid,
    input  wire logic                   result_ready,
    output bhpq_pkg::key_t              result_top_key,
    output bhpq_pkg::status_code_t      result_status,
    output bhpq_pkg::count_t            result_entry_count
);
    import bhpq_pkg::*;

    key_t                heap_mem [DEPTH];
    key_t                rd_data_reg;

    logic                mode_reg, mode_next;
    cmd_code_t           op_reg, op_next;
    key_t                key_reg, key_next;
    key_t                left_key_reg, left_key_next;
    key_t                top_reg, top_next;
    status_code_t        status_reg, status_next;
    count_t              count_reg, count_next;
    logic [ADDR_W-1:0]   pos_reg, pos_next;

    logic                out_valid_reg, out_valid_next;
    key_t                out_key_reg, out_key_next;
    status_code_t        out_status_reg, out_status_next;
    count_t              out_count_reg, out_count_next;

    logic [ADDR_W-1:0]   parent_pos;
    logic [ADDR_W-1:0]   tail_pos;
    logic [IDX_W-1:0]    left_idx;
    logic [IDX_W-1:0]    right_idx;
    logic [IDX_W-1:0]    count_idx;
    logic                left_ok;
    logic                right_ok;
    logic                empty;
    logic                full;
    logic                up_win;
    logic                l_win;
    logic                r_win;
    key_t                best_key;
    logic                dn_move;
    key_t                move_key;
    logic [ADDR_W-1:0]   move_pos;

    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    key_t                wr_data;

    assign parent_pos = ADDR_W'((pos_reg - 1'b1) >> 1);
    assign tail_pos   = ADDR_W'(count_reg - 1'b1);
    assign left_idx   = IDX_W'({pos_reg, 1'b1});
    assign right_idx  = left_idx + 1'b1;
    assign count_idx  = IDX_W'(count_reg);
    assign left_ok    = (left_idx < count_idx);
    assign right_ok   = (right_idx < count_idx);
    assign empty      = (count_reg == '0);
    assign full       = (count_reg == COUNT_W'(DEPTH));

    // sift compares
    assign up_win   = outranks(key_reg, rd_data_reg, mode_reg);
    assign l_win    = outranks(left_key_reg, key_reg, mode_reg);
    assign best_key = l_win ? left_key_reg : key_reg;
    assign r_win    = right_ok && outranks(rd_data_reg, best_key, mode_reg);
    assign dn_move  = l_win || r_win;
    assign move_key = r_win ? rd_data_reg : left_key_reg;
    assign move_pos = r_win ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

    assign stat.cmd      = op_reg;
    assign stat.empty    = empty;
    assign stat.full     = full;
    assign stat.pos_zero = (pos_reg == '0);
    assign stat.up_win   = up_win;
    assign stat.left_ok  = left_ok;
    assign stat.dn_move  = dn_move;
    assign stat.out_free = !out_valid_reg || result_ready;

    assign cfg_ready          = 1'b1;
    assign result_valid       = out_valid_reg;
    assign result_top_key     = out_key_reg;
    assign result_status      = out_status_reg;
    assign result_entry_count = out_count_reg;

    // memory port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (cmd.rd_root)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
        else if (cmd.rd_tail)
        begin
            rd_en   = 1'b1;
            rd_addr = tail_pos;
        end
        else if (cmd.rd_parent)
        begin
            rd_en   = 1'b1;
            rd_addr = parent_pos;
        end
        else if (cmd.rd_left)
        begin
            rd_en   = 1'b1;
            rd_addr = left_idx[ADDR_W-1:0];
        end
        else if (cmd.rd_right)
        begin
            rd_en   = right_ok;
            rd_addr = right_idx[ADDR_W-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_reg;
        wr_data = key_reg;
        if (cmd.put_key)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.up_step)
        begin
            wr_en   = 1'b1;
            wr_data = up_win ? rd_data_reg : key_reg;
        end
        else if (cmd.dn_step)
        begin
            wr_en   = 1'b1;
            wr_data = dn_move ? move_key : key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= heap_mem[rd_addr];
        end
    end

    always_comb
    begin
        mode_next       = mode_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        left_key_next   = left_key_reg;
        top_next        = top_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg;
        out_key_next    = out_key_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        if (cfg_valid)
        begin
            mode_next = cfg_order_mode;
        end
        if (cmd.take_item)
        begin
            op_next  = item_command;
            key_next = item_key;
        end
        if (cmd.set_result)
        begin
            top_next    = '0;
            status_next = ST_OK;
            if (op_reg == CMD_INSERT && full)
            begin
                status_next = ST_FULL;
            end
            else if ((op_reg == CMD_POP || op_reg == CMD_PEEK) && empty)
            begin
                status_next = ST_EMPTY;
            end
        end
        if (cmd.hole_tail)
        begin
            pos_next   = ADDR_W'(count_reg);
            count_next = count_reg + 1'b1;
        end
        if (cmd.up_step && up_win)
        begin
            pos_next = parent_pos;
        end
        if (cmd.take_top)
        begin
            top_next = rd_data_reg;
        end
        if (cmd.shrink)
        begin
            count_next = count_reg - 1'b1;
        end
        if (cmd.take_tail)
        begin
            key_next = rd_data_reg;
            pos_next = '0;
        end
        if (cmd.take_left)
        begin
            left_key_next = rd_data_reg;
        end
        if (cmd.dn_step && dn_move)
        begin
            pos_next = move_pos;
        end

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.emit)
        begin
            out_valid_next  = 1'b1;
            out_key_next    = top_reg;
            out_status_next = status_reg;
            out_count_next  = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        left_key_reg   <= left_key_next;
        top_reg        <= top_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        out_key_reg    <= out_key_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bhpq_ctrl.sv =====
// bhpq_ctrl: command sequencer for insert, pop and peek, one transaction at a time
// depends on bhpq_pkg; drives bhpq_datapath through bhpq_cmd_t
`default_nettype none

module bhpq_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   item_valid,
    output logic                        item_ready,
    input  wire bhpq_pkg::bhpq_stat_t   stat,
    output bhpq_pkg::bhpq_cmd_t         cmd
);
    import bhpq_pkg::*;

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DECODE    = 4'd1;
    localparam logic [3:0] S_UP_RD     = 4'd2;
    localparam logic [3:0] S_UP_CMP    = 4'd3;
    localparam logic [3:0] S_POP_ROOT  = 4'd4;
    localparam logic [3:0] S_POP_TAIL  = 4'd5;
    localparam logic [3:0] S_DN_LEFT   = 4'd6;
    localparam logic [3:0] S_DN_RIGHT  = 4'd7;
    localparam logic [3:0] S_DN_CMP    = 4'd8;
    localparam logic [3:0] S_PEEK_WAIT = 4'd9;
    localparam logic [3:0] S_FIN       = 4'd10;

    logic [3:0] state_reg, state_next;

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.set_result = 1'b1;
                state_next     = S_FIN;
                case (stat.cmd)
                    CMD_INSERT:
                    begin
                        if (!stat.full)
                        begin
                            cmd.hole_tail = 1'b1;
                            state_next    = S_UP_RD;
                        end
                    end
                    CMD_POP:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.rd_root = 1'b1;
                            state_next  = S_POP_ROOT;
                        end
                    end
                    CMD_PEEK:
                    begin
                        if (!stat.empty)
                        begin
                            cmd.rd_root = 1'b1;
                            state_next  = S_PEEK_WAIT;
                        end
                    end
                    default:
                    begin
                        state_next = S_FIN;
                    end
                endcase
            end
            S_UP_RD:
            begin
                if (stat.pos_zero)
                begin
                    cmd.put_key = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                cmd.up_step = 1'b1;
                state_next  = stat.up_win ? S_UP_RD : S_FIN;
            end
            S_POP_ROOT:
            begin
                cmd.take_top = 1'b1;
                cmd.rd_tail  = 1'b1;
                cmd.shrink   = 1'b1;
                state_next   = S_POP_TAIL;
            end
            S_POP_TAIL:
            begin
                cmd.take_tail = 1'b1;
                state_next    = stat.empty ? S_FIN : S_DN_LEFT;
            end
            S_DN_LEFT:
            begin
                if (stat.left_ok)
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = S_DN_RIGHT;
                end
                else
                begin
                    cmd.put_key = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_DN_RIGHT:
            begin
                cmd.take_left = 1'b1;
                cmd.rd_right  = 1'b1;
                state_next    = S_DN_CMP;
            end
            S_DN_CMP:
            begin
                cmd.dn_step = 1'b1;
                state_next  = stat.dn_move ? S_DN_LEFT : S_FIN;
            end
            S_PEEK_WAIT:
            begin
                cmd.take_top = 1'b1;
                state_next   = S_FIN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/binary_heap_priority_queue.sv =====
// binary_heap_priority_queue: top level joining the controller and the datapath
// depends on bhpq_pkg, bhpq_if, bhpq_ctrl and bhpq_datapath
// Priority queue of up to 1024 32-bit keys kept as a binary heap in a single-port-read,
// single-port-write memory. Each item transaction is a command: insert, pop or peek; each
// gives exactly one result transaction with the key, a status and the count after the
// command. Commands run one at a time. Insert sifts the new key up level by level, pop
// sifts the tail key down level by level; an error, the unused command 3 and peek leave
// the heap unchanged. Each insert step does one memory read and one compare, each pop
// step two reads and one compare.
// A new command is taken as soon as the previous one is finished, while its result may
// still wait in the output register; a result still waiting there holds the next command
// in its last cycle. order_mode is 0 for largest first, 1 for smallest
// first, and should only be written while the queue is idle.
`default_nettype none

module binary_heap_priority_queue (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bhpq_item_if.sink    item,
    bhpq_result_if.source result,
    bhpq_cfg_if.sink     cfg
);
    import bhpq_pkg::*;

    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;

    bhpq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    bhpq_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .item_command       (item.command),
        .item_key           (item.key),
        .cfg_valid          (cfg.valid),
        .cfg_order_mode     (cfg.order_mode),
        .cfg_ready          (cfg.ready),
        .cmd                (cmd),
        .stat               (stat),
        .result_valid       (result.valid),
        .result_ready       (result.ready),
        .result_top_key     (result.top_key),
        .result_status      (result.status),
        .result_entry_count (result.entry_count)
    );

endmodule

`default_nettype wire

// ===== test/tb_binary_heap_priority_queue.sv =====
// tb_binary_heap_priority_queue: self-checking testbench of the binary heap priority queue
// drives item and mode register transactions, predicts each result and checks it in order
// depends on bhpq_pkg, bhpq_if and the binary_heap_priority_queue rtl
`timescale 1ns / 1ps

module tb_binary_heap_priority_queue;
    import bhpq_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 7;
    localparam int SETTLE_CYCLES  = 60;
    localparam int TIMEOUT_CYCLES = 600000;
    localparam int MAX_PRINTED    = 40;

    localparam cmd_code_t CMD_UNUSED = 2'd3;
    localparam logic MODE_LARGEST  = 1'b0;
    localparam logic MODE_SMALLEST = 1'b1;

    typedef struct {
        key_t         top_key;
        status_code_t status;
        count_t       entry_count;
    } heap_result_t;

    logic clk;
    logic rst_n;

    bhpq_item_if   item_ch ();
    bhpq_result_if result_ch ();
    bhpq_cfg_if    cfg_ch ();

    binary_heap_priority_queue u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // predicted heap contents and mode
    key_t        heap_model [DEPTH];
    int unsigned heap_fill;
    logic        smallest_first;

    heap_result_t pending_results [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           recv_hold_cycles;

    always #HALF_PERIOD clk = ~clk;

    function automatic logic ranks_ahead(key_t a, key_t b);
        if (smallest_first)
        begin
            return a < b;
        end
        return a > b;
    endfunction

    function automatic void predict_command(cmd_code_t cmd, key_t key);
        heap_result_t res;
        key_t         tmp;
        int unsigned  pos;
        int unsigned  parent;
        int unsigned  left;
        int unsigned  right;
        int unsigned  best;
        res.top_key = '0;
        res.status  = ST_OK;
        if (cmd == CMD_INSERT)
        begin
            if (heap_fill >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                heap_model[heap_fill] = key;
                pos = heap_fill;
                heap_fill++;
                while (pos > 0)
                begin
                    parent = (pos - 1) / 2;
                    if (!ranks_ahead(heap_model[pos], heap_model[parent]))
                    begin
                        break;
                    end
                    tmp = heap_model[parent];
                    heap_model[parent] = heap_model[pos];
                    heap_model[pos] = tmp;
                    pos = parent;
                end
            end
        end
        else if (cmd == CMD_POP)
        begin
            if (heap_fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.top_key = heap_model[0];
                heap_model[0] = heap_model[heap_fill - 1];
                heap_fill--;
                pos = 0;
                forever
                begin
                    left  = pos * 2 + 1;
                    right = pos * 2 + 2;
                    best  = pos;
                    if (left < heap_fill && ranks_ahead(heap_model[left], heap_model[best]))
                    begin
                        best = left;
                    end
                    if (right < heap_fill && ranks_ahead(heap_model[right], heap_model[best]))
                    begin
                        best = right;
                    end
                    if (best == pos)
                    begin
                        break;
                    end
                    tmp = heap_model[best];
                    heap_model[best] = heap_model[pos];
                    heap_model[pos] = tmp;
                    pos = best;
                end
            end
        end
        else if (cmd == CMD_PEEK)
        begin
            if (heap_fill == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                res.top_key = heap_model[0];
            end
        end
        res.entry_count = count_t'(heap_fill);
        pending_results.push_back(res);
    endfunction

    task automatic report_error(string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("[%0t] ERROR: %s", $time, msg);
        end
    endtask

    // result checker
    always @(posedge clk)
    begin : check_results
        heap_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_error($sformatf("result transaction with nothing expected: key %h",
                                       result_ch.top_key));
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_ch.top_key !== want.top_key)
                begin
                    report_error($sformatf("top_key got %h want %h",
                                           result_ch.top_key, want.top_key));
                end
                if (result_ch.status !== want.status)
                begin
                    report_error($sformatf("status got %0d want %0d",
                                           result_ch.status, want.status));
                end
                if (result_ch.entry_count !== want.entry_count)
                begin
                    report_error($sformatf("entry_count got %0d want %0d",
                                           result_ch.entry_count, want.entry_count));
                end
            end
        end
    end

    // result side ready, with random stalls and long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
        end
        else if (recv_hold_cycles > 0)
        begin
            recv_hold_cycles = recv_hold_cycles - 1;
            result_ch.ready <= 1'b0;
        end
        else
        begin
            result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_command(cmd_code_t cmd, key_t key);
        if ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        item_ch.valid   <= 1'b1;
        item_ch.command <= cmd;
        item_ch.key     <= key;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        predict_command(cmd, key);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order_mode(logic mode);
        wait_drained();
        cfg_ch.valid      <= 1'b1;
        cfg_ch.order_mode <= mode;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
        smallest_first = mode;
        @(posedge clk);
    endtask

    function automatic key_t pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
        begin
            return '0;
        end
        if (sel < 16)
        begin
            return '1;
        end
        if (sel < 45)
        begin
            return key_t'($urandom_range(15));
        end
        return key_t'($urandom);
    endfunction

    task automatic random_traffic(int count, int insert_pct);
        int        sel;
        cmd_code_t cmd;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(99);
            if (sel < insert_pct)
            begin
                cmd = CMD_INSERT;
            end
            else if (sel < insert_pct + (100 - insert_pct) * 3 / 4)
            begin
                cmd = CMD_POP;
            end
            else
            begin
                cmd = CMD_PEEK;
            end
            send_command(cmd, pick_key());
        end
    endtask

    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_command(CMD_PEEK, '0);
        send_command(CMD_POP, 32'h1234_5678);
        send_command(CMD_UNUSED, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'd5);
        send_command(CMD_INSERT, 32'd5);
        send_command(CMD_INSERT, 32'd5);
        send_command(CMD_PEEK, 32'hDEAD_BEEF);
        send_command(CMD_INSERT, 32'd1);
        send_command(CMD_UNUSED, 32'd0);
        repeat (7) send_command(CMD_POP, '0);
        write_order_mode(MODE_SMALLEST);
        send_command(CMD_INSERT, 32'hAAAA_AAAA);
        send_command(CMD_INSERT, 32'h5555_5555);
        send_command(CMD_INSERT, 32'hFFFF_FFFF);
        send_command(CMD_INSERT, 32'h0000_0000);
        send_command(CMD_PEEK, '0);
        repeat (5) send_command(CMD_POP, '0);
        wait_drained();
    endtask

    task automatic test_random_no_idle();
        write_order_mode(MODE_LARGEST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        random_traffic(140, 55);
        wait_drained();
    endtask

    task automatic test_random_sender_idle();
        write_order_mode(MODE_SMALLEST);
        send_idle_pct  = 83;
        recv_stall_pct = 0;
        random_traffic(140, 50);
        wait_drained();
    endtask

    task automatic test_random_receiver_stall();
        write_order_mode(MODE_LARGEST);
        send_idle_pct  = 0;
        recv_stall_pct = 83;
        random_traffic(140, 45);
        wait_drained();
    endtask

    task automatic test_random_both_idle();
        write_order_mode(MODE_SMALLEST);
        send_idle_pct  = 9;
        recv_stall_pct = 9;
        random_traffic(140, 50);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_order_mode(MODE_LARGEST);
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        recv_hold_cycles = 500;
        random_traffic(16, 70);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        random_traffic(16, 40);
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        write_order_mode(MODE_SMALLEST);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (heap_fill < DEPTH)
        begin
            send_command(CMD_INSERT, pick_key());
        end
        repeat (3) send_command(CMD_INSERT, key_t'($urandom));
        send_command(CMD_PEEK, '0);
        repeat (40) send_command(CMD_POP, '0);
        send_command(CMD_INSERT, '1);
        // mode change only affects later compares
        write_order_mode(MODE_LARGEST);
        recv_stall_pct = 30;
        repeat (20) send_command(CMD_POP, '0);
        wait_drained();
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        item_ch.valid     = 1'b0;
        item_ch.command   = CMD_INSERT;
        item_ch.key       = '0;
        result_ch.ready   = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.order_mode = MODE_LARGEST;
        heap_fill         = 0;
        smallest_first    = MODE_LARGEST;
        error_count       = 0;
        send_idle_pct     = 0;
        recv_stall_pct    = 0;
        recv_hold_cycles  = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        test_backpressure();
        test_fill_to_capacity();

        wait_drained();
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("TEST FAILED");
        $finish;
    end

endmodule
